FILE: rtl/irpd_pkg.sv
package irpd_pkg;

	// Frame geometry
	localparam int unsigned FRAME_EDGES = 68;
	localparam int unsigned CNT_W       = 7;
	localparam int unsigned TIME_W      = 64;
	localparam int unsigned THR_W       = 30;
	localparam int unsigned CODE_W      = 16;
	localparam int unsigned OUTCOME_W   = 2;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned SHIFT_W     = 32;

	localparam logic [CNT_W-1:0] FIRST_BIT_EDGE = CNT_W'(4);
	localparam logic [CNT_W-1:0] LAST_BIT_EDGE  = CNT_W'(FRAME_EDGES - 2);
	localparam logic [CNT_W-1:0] CHECK_EDGE     = CNT_W'(FRAME_EDGES - 1);

	// Threshold reset values (ns)
	localparam logic [THR_W-1:0] LEADER_MIN_RST   = THR_W'(8000000);
	localparam logic [THR_W-1:0] LEADER_MAX_RST   = THR_W'(10000000);
	localparam logic [THR_W-1:0] REPEAT_SPACE_RST = THR_W'(3000000);
	localparam logic [THR_W-1:0] ONE_BIT_MIN_RST  = THR_W'(1000000);
	localparam logic [THR_W-1:0] TIMEOUT_RST      = THR_W'(30000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEADER_MIN   = 3'd0,
		REG_LEADER_MAX   = 3'd1,
		REG_REPEAT_SPACE = 3'd2,
		REG_ONE_BIT_MIN  = 3'd3,
		REG_TIMEOUT      = 3'd4
	} cfg_reg_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_NEW_FRAME  = 2'd0,
		OUT_REPEAT     = 2'd1,
		OUT_CHECK_FAIL = 2'd2
	} outcome_t;

	typedef struct packed {
		logic [THR_W-1:0] leader_min;
		logic [THR_W-1:0] leader_max;
		logic [THR_W-1:0] repeat_space_max;
		logic [THR_W-1:0] one_bit_min;
		logic [THR_W-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] key_code;
		outcome_t          outcome;
	} result_t;

endpackage

FILE: rtl/irpd_if.sv
// Edge channel: one receiver pin edge per transfer
interface irpd_edge_if;
	logic                          valid;
	logic                          ready;
	logic [irpd_pkg::TIME_W-1:0]   edge_time_ns;

	modport source (output valid, output edge_time_ns, input ready);
	modport sink   (input valid, input edge_time_ns, output ready);
endinterface

// Key channel: one decoded result per transfer
interface irpd_key_if;
	logic                            valid;
	logic                            ready;
	logic [irpd_pkg::CODE_W-1:0]     key_code;
	logic [irpd_pkg::OUTCOME_W-1:0]  outcome;

	modport source (output valid, output key_code, output outcome, input ready);
	modport sink   (input valid, input key_code, input outcome, output ready);
endinterface

// Configuration write channel
interface irpd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [irpd_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [irpd_pkg::THR_W-1:0]      wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: rtl/ir_pulse_distance_decoder_core.sv
// Each edge is registered in the input register, and its result then loads into the result
// register, which drives the key channel.
// Throughput: one edge per cycle; an edge register and a result register
// separate the two channels, so a held result stalls the input only once both fill.
// Reset (arst_n low, asynchronous): thresholds return to their defaults,
// frame state, stored timestamp and last code clear to zero, both channels empty.
module ir_pulse_distance_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	irpd_edge_if.sink   edge_in,
	irpd_key_if.source  key_out,
	irpd_cfg_if.sink    cfg
);

	logic                        valid_s1;
	logic [irpd_pkg::TIME_W-1:0] time_s1;
	logic                        advance;
	logic                        key_valid_q;
	logic [irpd_pkg::CODE_W-1:0] key_code_q;
	irpd_pkg::outcome_t          outcome_q;
	irpd_pkg::cfg_t              cfg_q;
	irpd_pkg::result_t           result;

	// Edge stage moves on when the result register is free or draining
	assign advance       = valid_s1 && (!key_valid_q || key_out.ready);
	assign edge_in.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (edge_in.ready) begin
			valid_s1 <= edge_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (edge_in.valid && edge_in.ready) begin
			time_s1 <= edge_in.edge_time_ns;
		end
	end

	// Configuration registers, writes always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.leader_min       <= irpd_pkg::LEADER_MIN_RST;
			cfg_q.leader_max       <= irpd_pkg::LEADER_MAX_RST;
			cfg_q.repeat_space_max <= irpd_pkg::REPEAT_SPACE_RST;
			cfg_q.one_bit_min      <= irpd_pkg::ONE_BIT_MIN_RST;
			cfg_q.timeout          <= irpd_pkg::TIMEOUT_RST;
		end else if (cfg.valid) begin
			unique case (irpd_pkg::cfg_reg_t'(cfg.reg_index))
				irpd_pkg::REG_LEADER_MIN:   cfg_q.leader_min       <= cfg.wr_data;
				irpd_pkg::REG_LEADER_MAX:   cfg_q.leader_max       <= cfg.wr_data;
				irpd_pkg::REG_REPEAT_SPACE: cfg_q.repeat_space_max <= cfg.wr_data;
				irpd_pkg::REG_ONE_BIT_MIN:  cfg_q.one_bit_min      <= cfg.wr_data;
				irpd_pkg::REG_TIMEOUT:      cfg_q.timeout          <= cfg.wr_data;
				default: ;
			endcase
		end
	end

	// Frame decode
	irpd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.edge_time (time_s1),
		.cfg       (cfg_q),
		.result    (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance) begin
			key_valid_q <= result.valid;
		end else if (key_out.ready) begin
			key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			key_code_q <= result.key_code;
			outcome_q  <= result.outcome;
		end
	end

	assign key_out.valid    = key_valid_q;
	assign key_out.key_code = key_code_q;
	assign key_out.outcome  = outcome_q;

endmodule

FILE: rtl/irpd_frame.sv
// Frame tracker: interval classification, bit gathering and checks
module irpd_frame (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [irpd_pkg::TIME_W-1:0]   edge_time,
	input  irpd_pkg::cfg_t                cfg,
	output irpd_pkg::result_t             result
);

	logic [irpd_pkg::TIME_W-1:0]  last_time_q, last_time_n;
	logic [irpd_pkg::CNT_W-1:0]   edge_cnt_q, edge_cnt_n;
	logic                         leader_ok_q, leader_ok_n;
	logic                         short_space_q, short_space_n;
	logic [irpd_pkg::SHIFT_W-1:0] shifter_q, shifter_n;
	logic [irpd_pkg::CODE_W-1:0]  held_code_q, held_code_n;

	logic [irpd_pkg::TIME_W-1:0]  delta;
	logic                         delta_narrow;
	logic [irpd_pkg::THR_W-1:0]   delta_lo;
	logic                         over_timeout;
	logic                         leader_in_window;
	logic                         space_short;
	logic                         bit_one;
	logic                         is_bit_edge;
	logic [7:0]                   addr, naddr, cmd, ncmd;

	// Interval since previous edge, wraps mod 2^64
	assign delta        = edge_time - last_time_q;
	assign delta_narrow = (delta[irpd_pkg::TIME_W-1:irpd_pkg::THR_W] == '0);
	assign delta_lo     = delta[irpd_pkg::THR_W-1:0];

	// Threshold compares against 30-bit registers
	assign over_timeout     = !delta_narrow || (delta_lo > cfg.timeout);
	assign leader_in_window = (!delta_narrow || (delta_lo > cfg.leader_min))
		&& delta_narrow && (delta_lo < cfg.leader_max);
	assign space_short      = delta_narrow && (delta_lo < cfg.repeat_space_max);
	assign bit_one          = !delta_narrow || (delta_lo > cfg.one_bit_min);

	assign is_bit_edge = (edge_cnt_q >= irpd_pkg::FIRST_BIT_EDGE)
		&& (edge_cnt_q <= irpd_pkg::LAST_BIT_EDGE) && !edge_cnt_q[0];

	assign addr  = shifter_q[7:0];
	assign naddr = shifter_q[15:8];
	assign cmd   = shifter_q[23:16];
	assign ncmd  = shifter_q[31:24];

	// Next state and result
	always_comb begin
		last_time_n     = edge_time;
		edge_cnt_n      = edge_cnt_q + 1'b1;
		leader_ok_n     = leader_ok_q;
		short_space_n   = short_space_q;
		shifter_n       = shifter_q;
		held_code_n     = held_code_q;
		result.valid    = 1'b0;
		result.key_code = '0;
		result.outcome  = irpd_pkg::OUT_NEW_FRAME;

		priority if (edge_cnt_q != '0 && over_timeout) begin
			// restart, this edge becomes edge 0
			edge_cnt_n = irpd_pkg::CNT_W'(1);
		end else if (edge_cnt_q == irpd_pkg::CNT_W'(1)) begin
			leader_ok_n = leader_in_window;
		end else if (edge_cnt_q == irpd_pkg::CNT_W'(2)) begin
			short_space_n = space_short;
		end else if (edge_cnt_q == irpd_pkg::CNT_W'(3)) begin
			if (leader_ok_q && short_space_q) begin
				edge_cnt_n      = '0;
				result.valid    = 1'b1;
				result.key_code = held_code_q;
				result.outcome  = irpd_pkg::OUT_REPEAT;
			end
		end else if (is_bit_edge) begin
			// LSB first: new bit enters at the top
			shifter_n = {bit_one, shifter_q[irpd_pkg::SHIFT_W-1:1]};
		end else if (edge_cnt_q >= irpd_pkg::CHECK_EDGE) begin
			edge_cnt_n   = '0;
			result.valid = 1'b1;
			if (addr != ~naddr || cmd != ~ncmd) begin
				result.outcome = irpd_pkg::OUT_CHECK_FAIL;
			end else begin
				held_code_n     = {addr, cmd};
				result.key_code = {addr, cmd};
				result.outcome  = irpd_pkg::OUT_NEW_FRAME;
			end
		end else begin
			// edge 0 and odd data edges only count
			edge_cnt_n = edge_cnt_q + 1'b1;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q   <= '0;
			edge_cnt_q    <= '0;
			leader_ok_q   <= 1'b0;
			short_space_q <= 1'b0;
			shifter_q     <= '0;
			held_code_q   <= '0;
		end else if (step) begin
			last_time_q   <= last_time_n;
			edge_cnt_q    <= edge_cnt_n;
			leader_ok_q   <= leader_ok_n;
			short_space_q <= short_space_n;
			shifter_q     <= shifter_n;
			held_code_q   <= held_code_n;
		end
	end

endmodule
